[rtl/core/cau_pkg.sv]
package cau_pkg;

    localparam int DATA_W = 32;
    localparam int NUM_W = 80;
    localparam int DEN_W = 64;
    localparam int QW = 33;
    localparam int DIV_STAGES = QW + 1;

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_SUB = 2'd1;
    localparam logic [1:0] KIND_MUL = 2'd2;
    localparam logic [1:0] KIND_DIV = 2'd3;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic              ovf;
        logic [DATA_W-1:0] val;
    } sat_t;

    typedef struct packed {
        logic              div;
        logic              dz;
        logic              neg_r;
        logic              neg_i;
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic              ovf;
    } side_t;

    function automatic sat_t sat_wide(input logic signed [64:0] x);
        sat_t r;
        r.ovf = 1'b0;
        r.val = x[DATA_W-1:0];
        if (x > 65'sh0_7FFF_FFFF)
        begin
            r.ovf = 1'b1;
            r.val = SAT_MAX;
        end
        else if (x < -65'sh0_8000_0000)
        begin
            r.ovf = 1'b1;
            r.val = SAT_MIN;
        end
        return r;
    endfunction

    function automatic sat_t sat_quot(input logic neg, input logic [QW-1:0] q,
                                      input logic hi_ovf);
        sat_t r;
        r.ovf = 1'b0;
        r.val = neg ? (~q[DATA_W-1:0] + 1'b1) : q[DATA_W-1:0];
        if (!neg && (hi_ovf || q[QW-1] || q[QW-2]))
        begin
            r.ovf = 1'b1;
            r.val = SAT_MAX;
        end
        else if (neg && (hi_ovf || q > {2'b01, {(QW-2){1'b0}}}))
        begin
            r.ovf = 1'b1;
            r.val = SAT_MIN;
        end
        return r;
    endfunction

endpackage

[rtl/core/cau_div_lane.sv]
module cau_div_lane (
    input  logic                     clk,
    input  logic                     en,
    input  logic [cau_pkg::NUM_W-1:0] n,
    input  logic [cau_pkg::DEN_W-1:0] d,
    output logic [cau_pkg::QW-1:0]    q,
    output logic                     q_ovf
);
    import cau_pkg::*;

    localparam int HI_W = NUM_W - QW;

    logic [DEN_W-1:0] d_reg   [0:QW];
    logic [DEN_W-1:0] rem_reg [0:QW];
    logic [QW-1:0]    lo_reg  [0:QW];
    logic [QW-1:0]    q_reg   [0:QW];
    logic             ovf_reg [0:QW];

    logic [DEN_W-1:0] hi_ext;
    logic             hi_ge;

    assign hi_ext = {{(DEN_W-HI_W){1'b0}}, n[NUM_W-1:QW]};
    assign hi_ge  = hi_ext >= d;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0]   <= d;
            rem_reg[0] <= hi_ge ? '0 : hi_ext;
            lo_reg[0]  <= n[QW-1:0];
            q_reg[0]   <= '0;
            ovf_reg[0] <= hi_ge;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        logic [DEN_W:0] t;
        logic [DEN_W:0] diff;
        logic           ge;

        assign t    = {rem_reg[k-1], lo_reg[k-1][QW-1]};
        assign ge   = t >= {1'b0, d_reg[k-1]};
        assign diff = t - {1'b0, d_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k]   <= d_reg[k-1];
                rem_reg[k] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
                lo_reg[k]  <= {lo_reg[k-1][QW-2:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][QW-2:0], ge};
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign q     = q_reg[QW];
    assign q_ovf = ovf_reg[QW];

endmodule

[rtl/core/complex_arithmetic_unit.sv]
// Channel  | Handshake           | Payload
// ---------+---------------------+------------------------------------------
// input    | in_valid, in_ready  | kind, a_real, a_imag, b_real, b_imag
// output   | out_valid, out_ready| out_real, out_imag, divide_by_zero, overflow
//
// One item enters per cycle while the output is not stalled; every item passes
// multiply and sum stages, the one-bit-per-stage restoring divider (34 stages)
// and an output stage. All kinds use the same latency, so order is kept.
// rst_n clears the valid bits only. A stalled output freezes every stage;
// in_ready is high whenever the output register is empty or being taken.
module complex_arithmetic_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        kind,
    input  logic signed [cau_pkg::DATA_W-1:0] a_real,
    input  logic signed [cau_pkg::DATA_W-1:0] a_imag,
    input  logic signed [cau_pkg::DATA_W-1:0] b_real,
    input  logic signed [cau_pkg::DATA_W-1:0] b_imag,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [cau_pkg::DATA_W-1:0] out_real,
    output logic signed [cau_pkg::DATA_W-1:0] out_imag,
    output logic                              divide_by_zero,
    output logic                              overflow
);
    import cau_pkg::*;

    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    logic v1_reg, v2_reg, v3_reg;
    logic v_reg [0:DIV_STAGES-1];
    logic out_valid_reg;

    logic [1:0]         k1_reg;
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, m_r_reg, m_i_reg;
    logic signed [32:0] ab_re1_reg, ab_im1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_reg     <= kind;
            p_rr_reg   <= a_real * b_real;
            p_ii_reg   <= a_imag * b_imag;
            p_ri_reg   <= a_real * b_imag;
            p_ir_reg   <= a_imag * b_real;
            m_r_reg    <= b_real * b_real;
            m_i_reg    <= b_imag * b_imag;
            ab_re1_reg <= (kind == KIND_SUB) ? ({a_real[31], a_real} - {b_real[31], b_real})
                                             : ({a_real[31], a_real} + {b_real[31], b_real});
            ab_im1_reg <= (kind == KIND_SUB) ? ({a_imag[31], a_imag} - {b_imag[31], b_imag})
                                             : ({a_imag[31], a_imag} + {b_imag[31], b_imag});
        end
    end

    logic [1:0]         k2_reg;
    logic signed [64:0] mul_re_reg, mul_im_reg, nr_reg, ni_reg;
    logic [DEN_W-1:0]   mag2_reg;
    logic signed [32:0] ab_re2_reg, ab_im2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k2_reg     <= k1_reg;
            mul_re_reg <= $signed({p_rr_reg[63], p_rr_reg} - {p_ii_reg[63], p_ii_reg}) >>> 16;
            mul_im_reg <= $signed({p_ri_reg[63], p_ri_reg} + {p_ir_reg[63], p_ir_reg}) >>> 16;
            nr_reg     <= {p_rr_reg[63], p_rr_reg} + {p_ii_reg[63], p_ii_reg};
            ni_reg     <= {p_ir_reg[63], p_ir_reg} - {p_ri_reg[63], p_ri_reg};
            mag2_reg   <= m_r_reg[DEN_W-1:0] + m_i_reg[DEN_W-1:0];
            ab_re2_reg <= ab_re1_reg;
            ab_im2_reg <= ab_im1_reg;
        end
    end

    logic signed [64:0] sel_re, sel_im;
    sat_t               s_re, s_im;
    logic [64:0]        abs_r, abs_i;
    side_t              side_next;

    always_comb
    begin
        sel_re = (k2_reg == KIND_MUL) ? mul_re_reg : {{32{ab_re2_reg[32]}}, ab_re2_reg};
        sel_im = (k2_reg == KIND_MUL) ? mul_im_reg : {{32{ab_im2_reg[32]}}, ab_im2_reg};
        s_re   = sat_wide(sel_re);
        s_im   = sat_wide(sel_im);
        abs_r  = nr_reg[64] ? (~nr_reg + 1'b1) : nr_reg;
        abs_i  = ni_reg[64] ? (~ni_reg + 1'b1) : ni_reg;
        side_next.div   = (k2_reg == KIND_DIV);
        side_next.dz    = (k2_reg == KIND_DIV) && (mag2_reg == '0);
        side_next.neg_r = nr_reg[64];
        side_next.neg_i = ni_reg[64];
        side_next.re    = s_re.val;
        side_next.im    = s_im.val;
        side_next.ovf   = s_re.ovf || s_im.ovf;
    end

    side_t            side3_reg;
    logic [NUM_W-1:0] n_r3_reg, n_i3_reg;
    logic [DEN_W-1:0] mag3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg <= side_next;
            n_r3_reg  <= {abs_r[DEN_W-1:0], 16'b0};
            n_i3_reg  <= {abs_i[DEN_W-1:0], 16'b0};
            mag3_reg  <= mag2_reg;
        end
    end

    logic [QW-1:0] q_r, q_i;
    logic          q_r_ovf, q_i_ovf;

    cau_div_lane u_div_re (
        .clk   (clk),
        .en    (en),
        .n     (n_r3_reg),
        .d     (mag3_reg),
        .q     (q_r),
        .q_ovf (q_r_ovf)
    );

    cau_div_lane u_div_im (
        .clk   (clk),
        .en    (en),
        .n     (n_i3_reg),
        .d     (mag3_reg),
        .q     (q_i),
        .q_ovf (q_i_ovf)
    );

    side_t side_reg [0:DIV_STAGES-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side3_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    side_t sd;
    sat_t  d_re, d_im;
    logic [DATA_W-1:0] out_real_next, out_imag_next;
    logic              dz_next, ovf_next;

    always_comb
    begin
        sd   = side_reg[DIV_STAGES-1];
        d_re = sat_quot(sd.neg_r, q_r, q_r_ovf);
        d_im = sat_quot(sd.neg_i, q_i, q_i_ovf);
        if (!sd.div)
        begin
            out_real_next = sd.re;
            out_imag_next = sd.im;
            dz_next       = 1'b0;
            ovf_next      = sd.ovf;
        end
        else if (sd.dz)
        begin
            out_real_next = '0;
            out_imag_next = '0;
            dz_next       = 1'b1;
            ovf_next      = 1'b0;
        end
        else
        begin
            out_real_next = d_re.val;
            out_imag_next = d_im.val;
            dz_next       = 1'b0;
            ovf_next      = d_re.ovf || d_im.ovf;
        end
    end

    logic [DATA_W-1:0] out_real_reg, out_imag_reg;
    logic              dz_reg, ovf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_real_reg <= out_real_next;
            out_imag_reg <= out_imag_next;
            dz_reg       <= dz_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v_reg[0] <= v3_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
            out_valid_reg <= v_reg[DIV_STAGES-1];
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_real       = out_real_reg;
    assign out_imag       = out_imag_reg;
    assign divide_by_zero = dz_reg;
    assign overflow       = ovf_reg;

endmodule

[rtl/core/cau_checker.sv]
module cau_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_real,
    input logic [31:0] out_imag,
    input logic        divide_by_zero,
    input logic        overflow
);
    import cau_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_real) && $stable(out_imag))
        else $error("output item changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output stall");

    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> out_real == '0 && out_imag == '0 && !overflow)
        else $error("zero divisor item not cleared");

    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> out_real == SAT_MAX || out_real == SAT_MIN ||
                                  out_imag == SAT_MAX || out_imag == SAT_MIN)
        else $error("overflow without a saturated part");

    a_rst: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("out_valid high in reset");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_real       (out_real),
    .out_imag       (out_imag),
    .divide_by_zero (divide_by_zero),
    .overflow       (overflow)
);

[test/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cau_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic              dz;
        logic              ovf;
    } cres_t;

    typedef struct packed {
        logic [1:0]        k;
        logic [DATA_W-1:0] ar;
        logic [DATA_W-1:0] ai;
        logic [DATA_W-1:0] br;
        logic [DATA_W-1:0] bi;
        logic              typed;
        cres_t             res;
    } row_t;

    localparam int N_DIR = 21;
    localparam int N_RAND = 1500;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD = 400;
    localparam logic [DATA_W-1:0] ONE = 32'h0001_0000;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] a_real;
    logic signed [DATA_W-1:0] a_imag;
    logic signed [DATA_W-1:0] b_real;
    logic signed [DATA_W-1:0] b_imag;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] out_real;
    logic signed [DATA_W-1:0] out_imag;
    logic                     divide_by_zero;
    logic                     overflow;

    cres_t expected_q[$];
    row_t  dir_tab [0:N_DIR-1];
    int    errors;
    int    n_results;
    int    n_kind [0:3];
    int    send_idle_pct;
    int    recv_stall_pct;
    int    hold_req;
    int    idle_run;

    complex_arithmetic_unit i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .a_real(a_real),
        .a_imag(a_imag),
        .b_real(b_real),
        .b_imag(b_imag),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_real(out_real),
        .out_imag(out_imag),
        .divide_by_zero(divide_by_zero),
        .overflow(overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [DATA_W-1:0] clip32(input logic signed [127:0] v,
                                                 inout logic ovf);
        if (v > 128'sh7FFF_FFFF)
        begin
            ovf = 1'b1;
            return SAT_MAX;
        end
        if (v < -128'sh8000_0000)
        begin
            ovf = 1'b1;
            return SAT_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    function automatic cres_t complex_result(input logic [1:0] k,
                                             input logic signed [DATA_W-1:0] ar, ai, br, bi);
        logic signed [127:0] xr, xi, yr, yi, re, im, mag;
        cres_t r;
        xr = ar;
        xi = ai;
        yr = br;
        yi = bi;
        r.dz = 1'b0;
        r.ovf = 1'b0;
        re = 0;
        im = 0;
        case (k)
            KIND_ADD:
            begin
                re = xr + yr;
                im = xi + yi;
            end
            KIND_SUB:
            begin
                re = xr - yr;
                im = xi - yi;
            end
            KIND_MUL:
            begin
                re = (xr * yr - xi * yi) >>> 16;
                im = (xr * yi + xi * yr) >>> 16;
            end
            default:
            begin
                mag = yr * yr + yi * yi;
                if (mag == 0)
                    r.dz = 1'b1;
                else
                begin
                    re = ((xr * yr + xi * yi) <<< 16) / mag;
                    im = ((xi * yr - xr * yi) <<< 16) / mag;
                end
            end
        endcase
        r.re = clip32(re, r.ovf);
        r.im = clip32(im, r.ovf);
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return SAT_MAX;
            1: return SAT_MIN;
            2: return 32'd0;
            3, 4: return $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] k, input logic [DATA_W-1:0] ar, ai, br, bi,
                             input logic typed, input cres_t res);
        int gap;
        in_valid <= 1'b1;
        kind <= k;
        a_real <= ar;
        a_imag <= ai;
        b_real <= br;
        b_imag <= bi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_q.push_back(typed ? res : complex_result(k, ar, ai, br, bi));
        n_kind[k]++;
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [1:0] k;
        logic [DATA_W-1:0] ar, ai, br, bi;
        int phase;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_ADD;
        a_real = '0;
        a_imag = '0;
        b_real = '0;
        b_imag = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 0;
        errors = 0;
        n_results = 0;
        for (int i = 0; i < 4; i++)
            n_kind[i] = 0;
        dir_tab = '{
            '{KIND_ADD, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b0, 1'b0}},
            '{KIND_ADD, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 1'b1, '{SAT_MAX, SAT_MAX, 1'b0, 1'b1}},
            '{KIND_ADD, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 1'b1, '{SAT_MIN, SAT_MIN, 1'b0, 1'b1}},
            '{KIND_ADD, SAT_MAX, 32'd0, SAT_MIN, 32'd0, 1'b0, '0},
            '{KIND_SUB, SAT_MIN, 32'd0, 32'd1, 32'd0, 1'b1, '{SAT_MIN, 32'd0, 1'b0, 1'b1}},
            '{KIND_SUB, SAT_MAX, SAT_MAX, 32'hFFFF_FFFF, 32'd0, 1'b1,
              '{SAT_MAX, SAT_MAX, 1'b0, 1'b1}},
            '{KIND_SUB, 32'd0, 32'd0, SAT_MIN, SAT_MIN, 1'b1, '{SAT_MAX, SAT_MAX, 1'b0, 1'b1}},
            '{KIND_MUL, ONE, 32'd0, ONE, 32'd0, 1'b1, '{ONE, 32'd0, 1'b0, 1'b0}},
            '{KIND_MUL, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 1'b1, '{32'd0, SAT_MAX, 1'b0, 1'b1}},
            '{KIND_MUL, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 1'b0, '0},
            '{KIND_MUL, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0, 1'b1,
              '{32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0}},
            '{KIND_MUL, 32'h0003_8000, 32'hFFFE_4000, 32'h0000_C000, 32'h0002_1000, 1'b0, '0},
            '{KIND_DIV, 32'd5, 32'd7, 32'd0, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b1, 1'b0}},
            '{KIND_DIV, SAT_MAX, SAT_MIN, 32'd0, 32'd0, 1'b1, '{32'd0, 32'd0, 1'b1, 1'b0}},
            '{KIND_DIV, ONE, 32'd0, ONE, 32'd0, 1'b1, '{ONE, 32'd0, 1'b0, 1'b0}},
            '{KIND_DIV, SAT_MIN, SAT_MIN, 32'd1, 32'd0, 1'b1, '{SAT_MIN, SAT_MIN, 1'b0, 1'b1}},
            '{KIND_DIV, 32'hFFFF_FFFF, 32'd0, 32'h0003_0000, 32'd0, 1'b0, '0},
            '{KIND_DIV, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 1'b0, '0},
            '{KIND_DIV, SAT_MIN, 32'd0, SAT_MIN, 32'd0, 1'b0, '0},
            '{KIND_DIV, 32'h0002_0000, 32'hFFFF_0000, 32'd0, 32'd1, 1'b0, '0},
            '{KIND_DIV, 32'd0, 32'd0, SAT_MIN, SAT_MIN, 1'b0, '0}
        };
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
            send_item(dir_tab[i].k, dir_tab[i].ar, dir_tab[i].ai, dir_tab[i].br,
                      dir_tab[i].bi, dir_tab[i].typed, dir_tab[i].res);
        drain();

        for (int n = 0; n < N_RAND; n++)
        begin
            phase = n / (N_RAND / 4);
            if (n % (N_RAND / 4) == 0)
            begin
                drain();
                send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 55 : 14) : 0;
                recv_stall_pct = (phase == 2) ? 55 : ((phase == 3) ? 14 : 0);
                if (phase == 2)
                    hold_req = LONG_HOLD;
            end
            k = $urandom_range(0, 3);
            ar = pick_operand();
            ai = pick_operand();
            br = pick_operand();
            bi = pick_operand();
            if (k == KIND_DIV && $urandom_range(0, 9) == 0)
            begin
                br = 32'd0;
                bi = 32'd0;
            end
            send_item(k, ar, ai, br, bi, 1'b0, '0);
        end

        drain();
        repeat (50) @(posedge clk);
        $display("covered %0d results: %0d add, %0d sub, %0d mul, %0d div",
                 n_results, n_kind[0], n_kind[1], n_kind[2], n_kind[3]);
        $display("directed extremes, zero divisors, random operands under idle and stall");
        if (errors == 0 && expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        cres_t e;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                n_results++;
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item %h %h %b %b", $time,
                             out_real, out_imag, divide_by_zero, overflow);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (out_real !== e.re)
                    begin
                        errors++;
                        $display("%0t: out_real expected %h actual %h", $time, e.re, out_real);
                    end
                    if (out_imag !== e.im)
                    begin
                        errors++;
                        $display("%0t: out_imag expected %h actual %h", $time, e.im, out_imag);
                    end
                    if (divide_by_zero !== e.dz)
                    begin
                        errors++;
                        $display("%0t: divide_by_zero expected %b actual %b", $time, e.dz,
                                 divide_by_zero);
                    end
                    if (overflow !== e.ovf)
                    begin
                        errors++;
                        $display("%0t: overflow expected %b actual %b", $time, e.ovf, overflow);
                    end
                end
            end
            if (hold_req > 0)
            begin
                hold_req--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        idle_run = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
